@@ rtl/core/dce_pkg.sv @@
package dce_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 48;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_CHANNEL_CONTROL    = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_ELEMENTS_PER_FRAME = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_FRAMES_PER_BLOCK   = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_SOURCE_START       = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_DEST_START         = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_SOURCE_INDICES     = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_DEST_INDICES       = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_FILL_COLOR         = 3'd7;

  // Request opcodes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ELEMENT = 1'b1;

  // Addressing modes
  localparam logic [1:0] MODE_CONST    = 2'd0;
  localparam logic [1:0] MODE_POST_INC = 2'd1;
  localparam logic [1:0] MODE_SINGLE   = 2'd2;
  localparam logic [1:0] MODE_DOUBLE   = 2'd3;

  // Element size codes
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_FAULT = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] source_data;
  } in_t;

  typedef struct packed {
    logic [31:0] next_source_address;
    logic [31:0] dest_address;
    logic [31:0] dest_data;
    logic        dest_write;
    logic        frame_end;
    logic        block_end;
    logic        misalign_fault;
  } out_t;

  function automatic logic [31:0] width_mask(input logic [1:0] code);
    unique case (code)
      SIZE_BYTE: width_mask = 32'h0000_00FF;
      SIZE_HALF: width_mask = 32'h0000_FFFF;
      default:   width_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] align_mask(input logic [1:0] code);
    unique case (code)
      SIZE_BYTE: align_mask = 32'd0;
      SIZE_HALF: align_mask = 32'd1;
      SIZE_WORD: align_mask = 32'd3;
      default:   align_mask = 32'd7;
    endcase
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] v, input logic [1:0] code);
    unique case (code)
      SIZE_BYTE: swap_bytes = {24'd0, v[7:0]};
      SIZE_HALF: swap_bytes = {16'd0, v[7:0], v[15:8]};
      default:   swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endcase
  endfunction

  // Element index sits in bits 15:0, frame index in bits 47:16
  function automatic logic [31:0] step_addr(input logic [31:0] cur, input logic [1:0] mode,
                                            input logic [47:0] idx, input logic [1:0] code,
                                            input logic eof);
    logic [31:0] es;
    logic [31:0] ei;
    logic [31:0] fi;
    es = 32'd1 << code;
    ei = {{16{idx[15]}}, idx[15:0]};
    fi = idx[47:16];
    unique case (mode)
      MODE_POST_INC: step_addr = cur + es;
      MODE_SINGLE:   step_addr = cur + es + ei - 32'd1;
      MODE_DOUBLE:   step_addr = cur + es + (eof ? fi : ei) - 32'd1;
      default:       step_addr = cur;
    endcase
  endfunction

endpackage

@@ rtl/core/dma_channel_element_engine.sv @@
// Element engine of one 2-D DMA channel. A start request clears the element and
// frame counters and loads the source and destination pointers from the start
// registers; a zero count ends the block at once instead. Each element request
// carries the data read at the current source address and produces one result
// with the destination address, data and write flag; unless it faults or the
// channel is idle, both pointers then step (the source one not in fill mode) in
// constant, post-increment, single-index or double-index mode. Rate: one request
// per clock unless in_stall is high (input register, then result register); a
// result-side stall backs up into in_stall only once both registers are full.
// Configure only while no request is in flight; cfg_ready is always high.
module dma_channel_element_engine
  import dce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  logic [9:0]  channel_control_r;
  logic [23:0] elements_per_frame_r;
  logic [15:0] frames_per_block_r;
  logic [31:0] source_start_r;
  logic [31:0] dest_start_r;
  logic [47:0] source_indices_r;
  logic [47:0] dest_indices_r;
  logic [31:0] fill_color_r;

  logic [31:0] source_pointer_r, source_pointer_nxt;
  logic [31:0] dest_pointer_r, dest_pointer_nxt;
  logic [23:0] element_counter_r, element_counter_nxt;
  logic [15:0] frame_counter_r, frame_counter_nxt;
  logic        running_r, running_nxt;
  logic        block_flag_r, block_flag_nxt;

  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        out_valid_r;
  out_t        out_data_r, out_data_nxt;

  logic        out_free;
  logic        s1_move;

  logic [1:0]  smode, dmode, code;
  logic        cfill, transp, sswap, dswap;
  logic [31:0] wmask, amask;
  logic [31:0] spa, sval, ddata;
  logic        fault, doit, eof;
  logic [23:0] ec_inc;
  logic [15:0] fc_inc;

  function automatic logic [31:0] in_data_mask(input logic [31:0] d, input logic [31:0] m,
                                               input logic swap, input logic [1:0] c);
    logic [31:0] v;
    v = d & m;
    in_data_mask = swap ? swap_bytes(v, c) : v;
  endfunction

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign smode  = channel_control_r[1:0];
  assign dmode  = channel_control_r[3:2];
  assign cfill  = channel_control_r[4];
  assign transp = channel_control_r[5];
  assign code   = channel_control_r[7:6];
  assign sswap  = channel_control_r[8];
  assign dswap  = channel_control_r[9];
  assign wmask  = width_mask(code);
  assign amask  = align_mask(code);
  assign spa    = (smode == MODE_CONST) ? source_start_r : source_pointer_r;
  assign ec_inc = element_counter_r + 24'd1;
  assign fc_inc = frame_counter_r + 16'd1;

  always_comb begin
    source_pointer_nxt  = source_pointer_r;
    dest_pointer_nxt    = dest_pointer_r;
    element_counter_nxt = element_counter_r;
    frame_counter_nxt   = frame_counter_r;
    running_nxt         = running_r;
    block_flag_nxt      = block_flag_r;
    sval                = 32'd0;
    ddata               = 32'd0;
    fault               = 1'b0;
    doit                = 1'b1;
    eof                 = 1'b0;
    out_data_nxt        = '0;
    out_data_nxt.dest_address = dest_pointer_r;

    if (s1_data_r.op == OP_START) begin
      element_counter_nxt = 24'd0;
      frame_counter_nxt   = 16'd0;
      if (elements_per_frame_r == 24'd0 || frames_per_block_r == 16'd0) begin
        running_nxt    = 1'b0;
        block_flag_nxt = 1'b1;
      end else begin
        source_pointer_nxt = source_start_r;
        dest_pointer_nxt   = dest_start_r;
        running_nxt        = 1'b1;
        block_flag_nxt     = 1'b0;
      end
      out_data_nxt.dest_address = dest_pointer_nxt;
    end else if (running_r) begin
      if (code == SIZE_FAULT) begin
        fault = 1'b1;
      end else if (cfill) begin
        sval = fill_color_r;
      end else begin
        fault = (spa & amask) != 32'd0;
        sval  = in_data_mask(s1_data_r.source_data, wmask, sswap, code);
      end
      if (!fault && transp && ((sval & wmask) == (fill_color_r & wmask))) begin
        doit = 1'b0;
      end
      if (!fault && doit) begin
        if ((dest_pointer_r & amask) != 32'd0) begin
          fault = 1'b1;
        end else begin
          ddata = (dswap ? swap_bytes(sval, code) : sval) & wmask;
          out_data_nxt.dest_write = 1'b1;
        end
      end
      if (fault) begin
        block_flag_nxt = 1'b1;
        running_nxt    = 1'b0;
        ddata          = 32'd0;
        out_data_nxt.dest_write = 1'b0;
      end else begin
        eof = ec_inc == elements_per_frame_r;
        if (!cfill) begin
          source_pointer_nxt = step_addr(source_pointer_r, smode, source_indices_r, code, eof);
        end
        dest_pointer_nxt = step_addr(dest_pointer_r, dmode, dest_indices_r, code, eof);
        if (eof) begin
          element_counter_nxt = 24'd0;
          frame_counter_nxt   = fc_inc;
          if (fc_inc == frames_per_block_r) begin
            block_flag_nxt = 1'b1;
            running_nxt    = 1'b0;
          end
        end else begin
          element_counter_nxt = ec_inc;
        end
      end
    end

    out_data_nxt.next_source_address =
      (smode == MODE_CONST) ? source_start_r : source_pointer_nxt;
    out_data_nxt.dest_data      = ddata;
    out_data_nxt.frame_end      = eof;
    out_data_nxt.block_end      = block_flag_nxt;
    out_data_nxt.misalign_fault = fault;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_control_r    <= '0;
      elements_per_frame_r <= '0;
      frames_per_block_r   <= '0;
      source_start_r       <= '0;
      dest_start_r         <= '0;
      source_indices_r     <= '0;
      dest_indices_r       <= '0;
      fill_color_r         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHANNEL_CONTROL:    channel_control_r    <= cfg_data[9:0];
        REG_ELEMENTS_PER_FRAME: elements_per_frame_r <= cfg_data[23:0];
        REG_FRAMES_PER_BLOCK:   frames_per_block_r   <= cfg_data[15:0];
        REG_SOURCE_START:       source_start_r       <= cfg_data[31:0];
        REG_DEST_START:         dest_start_r         <= cfg_data[31:0];
        REG_SOURCE_INDICES:     source_indices_r     <= cfg_data[47:0];
        REG_DEST_INDICES:       dest_indices_r       <= cfg_data[47:0];
        default:                fill_color_r         <= cfg_data[31:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_pointer_r  <= '0;
      dest_pointer_r    <= '0;
      element_counter_r <= '0;
      frame_counter_r   <= '0;
      running_r         <= 1'b0;
      block_flag_r      <= 1'b0;
    end else if (s1_move) begin
      source_pointer_r  <= source_pointer_nxt;
      dest_pointer_r    <= dest_pointer_nxt;
      element_counter_r <= element_counter_nxt;
      frame_counter_r   <= frame_counter_nxt;
      running_r         <= running_nxt;
      block_flag_r      <= block_flag_nxt;
    end
  end

  // Input register: load whenever it is empty or draining this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

@@ tb/sv/dma_channel_element_engine_tb.sv @@
module dma_channel_element_engine_tb
  import dce_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TARGET_REQS = 1350;

  localparam logic [3:0] FLAG_FRAME    = 4'b0001;
  localparam logic [3:0] FLAG_BLOCK    = 4'b0010;
  localparam logic [3:0] FLAG_LAST     = 4'b0100;
  localparam logic [3:0] FLAG_MISALIGN = 4'b1000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  dma_channel_element_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Channel registers as the engine sees them
  logic [9:0]  chan_ctl = '0;
  logic [23:0] elem_per_frame = '0;
  logic [15:0] frames_per_blk = '0;
  logic [31:0] src_base = '0;
  logic [31:0] dst_base = '0;
  logic [47:0] src_step_idx = '0;
  logic [47:0] dst_step_idx = '0;
  logic [31:0] fill_key = '0;

  // Engine state
  logic [31:0] src_ptr = '0;
  logic [31:0] dst_ptr = '0;
  logic [23:0] elem_cnt = '0;
  logic [15:0] frame_cnt = '0;
  logic        engine_busy = 1'b0;
  logic [3:0]  status = '0;

  in_t  pending_reqs[$];
  out_t expected_writes[$];
  int   queued_total = 0;
  int   req_count = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  logic req_fired = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] lane_mask(input logic [1:0] code);
    case (code)
      SIZE_BYTE: return 32'h0000_00FF;
      SIZE_HALF: return 32'h0000_FFFF;
      default:   return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] reverse_lanes(input logic [31:0] v, input logic [1:0] code);
    case (code)
      SIZE_BYTE: return {24'd0, v[7:0]};
      SIZE_HALF: return {16'd0, v[7:0], v[15:8]};
      default:   return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endcase
  endfunction

  function automatic logic [31:0] advance_addr(input logic [31:0] cur, input logic [1:0] mode,
                                               input logic [47:0] idx, input logic [31:0] es,
                                               input logic frame_done);
    logic [31:0] elem_jump;
    logic [31:0] frame_jump;
    elem_jump  = {{16{idx[15]}}, idx[15:0]};
    frame_jump = idx[47:16];
    case (mode)
      MODE_POST_INC: return cur + es;
      MODE_SINGLE:   return cur + es + elem_jump - 32'd1;
      MODE_DOUBLE:   return cur + es + (frame_done ? frame_jump : elem_jump) - 32'd1;
      default:       return cur;
    endcase
  endfunction

  // Apply one request to the engine state and return the write it produces
  function automatic out_t engine_step(input in_t req);
    out_t        res;
    logic [1:0]  smode;
    logic [1:0]  dmode;
    logic [1:0]  code;
    logic [31:0] es;
    logic [31:0] mask;
    logic [31:0] rd_addr;
    logic [31:0] sval;
    logic        fault;
    logic        skip;
    logic        frame_done;
    smode = chan_ctl[1:0];
    dmode = chan_ctl[3:2];
    code  = chan_ctl[7:6];
    es    = 32'd1 << code;
    mask  = lane_mask(code);
    res   = '0;
    res.dest_address = dst_ptr;
    if (req.op == OP_START) begin
      status = status & ~(FLAG_FRAME | FLAG_BLOCK | FLAG_LAST);
      elem_cnt = '0;
      frame_cnt = '0;
      engine_busy = 1'b0;
      if (elem_per_frame == 0 || frames_per_blk == 0) begin
        status = status | FLAG_FRAME | FLAG_BLOCK | FLAG_LAST;
      end else begin
        src_ptr = src_base;
        dst_ptr = dst_base;
        engine_busy = 1'b1;
      end
      res.dest_address = dst_ptr;
    end else if (engine_busy) begin
      sval  = '0;
      fault = 1'b0;
      skip  = 1'b0;
      if (code == SIZE_FAULT) begin
        fault = 1'b1;
      end else if (chan_ctl[4]) begin
        sval = fill_key;
      end else begin
        rd_addr = (smode == MODE_CONST) ? src_base : src_ptr;
        if ((rd_addr & (es - 32'd1)) != 0) fault = 1'b1;
        sval = req.source_data & mask;
        if (chan_ctl[8]) sval = reverse_lanes(sval, code);
      end
      if (!fault && chan_ctl[5] && (sval & mask) == (fill_key & mask)) skip = 1'b1;
      if (!fault && !skip) begin
        if ((dst_ptr & (es - 32'd1)) != 0) begin
          fault = 1'b1;
        end else begin
          res.dest_data = (chan_ctl[9] ? reverse_lanes(sval, code) : sval) & mask;
          res.dest_write = 1'b1;
        end
      end
      if (fault) begin
        status = status | FLAG_MISALIGN | FLAG_BLOCK;
        engine_busy = 1'b0;
        res.dest_data = '0;
      end else begin
        elem_cnt = elem_cnt + 24'd1;
        frame_done = (elem_cnt == elem_per_frame);
        if (!chan_ctl[4]) src_ptr = advance_addr(src_ptr, smode, src_step_idx, es, frame_done);
        dst_ptr = advance_addr(dst_ptr, dmode, dst_step_idx, es, frame_done);
        if (frame_done) begin
          res.frame_end = 1'b1;
          elem_cnt = '0;
          frame_cnt = frame_cnt + 16'd1;
          status = status | FLAG_FRAME;
          if (frame_cnt == frames_per_blk) begin
            status = status | FLAG_BLOCK | FLAG_LAST;
            engine_busy = 1'b0;
          end
        end
      end
      res.misalign_fault = fault;
    end
    res.next_source_address = (smode == MODE_CONST) ? src_base : src_ptr;
    res.block_end = (status & FLAG_BLOCK) != 0;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, got %h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      req_fired = rst_n && in_valid && !in_stall;
      if (req_fired) begin
        expected_writes.push_back(engine_step(in_data));
        req_count++;
      end
      if (rst_n && out_valid && !out_stall) begin
        if (expected_writes.size() == 0) begin
          $error("unexpected result %p", out_data);
          mismatches++;
        end else begin
          want = expected_writes.pop_front();
          check_field("next_source_address", want.next_source_address,
                      out_data.next_source_address);
          check_field("dest_address", want.dest_address, out_data.dest_address);
          check_field("dest_data", want.dest_data, out_data.dest_data);
          check_field("dest_write", 32'(want.dest_write), 32'(out_data.dest_write));
          check_field("frame_end", 32'(want.frame_end), 32'(out_data.frame_end));
          check_field("block_end", 32'(want.block_end), 32'(out_data.block_end));
          check_field("misalign_fault", 32'(want.misalign_fault),
                      32'(out_data.misalign_fault));
        end
      end
    end
  end

  // Driver: feed requests and result-side stalls at the falling edge
  always @(negedge clk) begin
    logic calm;
    calm = (req_count >= 500 && req_count < 800);
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 16);
      // hold the current request until it is taken
      if (!in_valid || req_fired) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CHANNEL_CONTROL:    chan_ctl = val[9:0];
      REG_ELEMENTS_PER_FRAME: elem_per_frame = val[23:0];
      REG_FRAMES_PER_BLOCK:   frames_per_blk = val[15:0];
      REG_SOURCE_START:       src_base = val[31:0];
      REG_DEST_START:         dst_base = val[31:0];
      REG_SOURCE_INDICES:     src_step_idx = val;
      REG_DEST_INDICES:       dst_step_idx = val;
      default:                fill_key = val[31:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic queue_req(input logic op, input logic [31:0] data);
    in_t req;
    req.op = op;
    req.source_data = data;
    pending_reqs.push_back(req);
    queued_total++;
  endtask

  task automatic wait_drained();
    while (req_count != queued_total || expected_writes.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_data();
    case ($urandom_range(19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return fill_key;
      3:       return ($urandom & 32'hFFFF_0000) | (fill_key & 32'h0000_FFFF);
      4:       return {fill_key[7:0], fill_key[15:8], fill_key[23:16], fill_key[31:24]};
      5:       return ($urandom & 32'hFFFF_0000) | {16'd0, fill_key[7:0], fill_key[15:8]};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(9))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0000_0000;
      2, 3:    return $urandom;
      default: return $urandom & 32'hFFFF_FFF8;
    endcase
  endfunction

  // Mostly steps that keep every element size aligned
  function automatic logic [47:0] rand_indices();
    logic [15:0] elem_jump;
    logic [31:0] frame_jump;
    case ($urandom_range(9))
      0:       return 48'hFFFF_FFFF_FFFF;
      1:       return 48'h0;
      2, 3:    return {$urandom, 16'($urandom)};
      default: begin
        elem_jump  = 16'(($urandom_range(8) - 4) * 8 + 1);
        frame_jump = 32'(($urandom_range(64) - 32) * 8 + 1);
        return {frame_jump, elem_jump};
      end
    endcase
  endfunction

  task automatic random_phase();
    logic [9:0] ctl;
    longint     span;
    int         n;
    if (engine_busy && $urandom_range(7) == 0) begin
      // lower the frame size mid-block and keep going
      write_reg(REG_ELEMENTS_PER_FRAME, 48'($urandom_range(3)));
      repeat ($urandom_range(1, 6)) queue_req(OP_ELEMENT, rand_data());
      return;
    end
    ctl = 10'($urandom);
    ctl[7:6] = ($urandom_range(9) == 0) ? SIZE_FAULT : 2'($urandom_range(2));
    ctl[4] = ($urandom_range(3) == 0);
    write_reg(REG_CHANNEL_CONTROL, 48'(ctl));
    case ($urandom_range(19))
      0:       write_reg(REG_ELEMENTS_PER_FRAME, 48'd0);
      1:       write_reg(REG_ELEMENTS_PER_FRAME, 48'hFF_FFFF);
      default: write_reg(REG_ELEMENTS_PER_FRAME, 48'($urandom_range(1, 6)));
    endcase
    case ($urandom_range(19))
      0:       write_reg(REG_FRAMES_PER_BLOCK, 48'd0);
      1:       write_reg(REG_FRAMES_PER_BLOCK, 48'hFFFF);
      default: write_reg(REG_FRAMES_PER_BLOCK, 48'($urandom_range(1, 4)));
    endcase
    write_reg(REG_SOURCE_START, 48'(rand_addr()));
    write_reg(REG_DEST_START, 48'(rand_addr()));
    write_reg(REG_SOURCE_INDICES, rand_indices());
    write_reg(REG_DEST_INDICES, rand_indices());
    case ($urandom_range(9))
      0:       write_reg(REG_FILL_COLOR, 48'h0);
      1:       write_reg(REG_FILL_COLOR, 48'hFFFF_FFFF);
      default: write_reg(REG_FILL_COLOR, 48'($urandom));
    endcase
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) queue_req(OP_ELEMENT, rand_data());
    queue_req(OP_START, rand_data());
    span = longint'(elem_per_frame) * longint'(frames_per_blk);
    if (span == 0) n = $urandom_range(2);
    else if (span > 24) n = $urandom_range(1, 24);
    else n = int'(span) + $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) queue_req(OP_START, rand_data());
      else queue_req(OP_ELEMENT, rand_data());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle channel: element before any start, zero count, element after it
    queue_req(OP_ELEMENT, 32'h0000_0000);
    queue_req(OP_START, 32'h0000_0000);
    queue_req(OP_ELEMENT, 32'hFFFF_FFFF);
    wait_drained();

    // two frames of two words, post-increment source, double-index destination
    write_reg(REG_CHANNEL_CONTROL,
              48'({1'b1, 1'b1, SIZE_WORD, 1'b0, 1'b0, MODE_DOUBLE, MODE_POST_INC}));
    write_reg(REG_ELEMENTS_PER_FRAME, 48'd2);
    write_reg(REG_FRAMES_PER_BLOCK, 48'd2);
    write_reg(REG_SOURCE_START, 48'h100);
    write_reg(REG_DEST_START, 48'h200);
    write_reg(REG_SOURCE_INDICES, {32'hFFFF_FFF1, 16'h0005});
    write_reg(REG_DEST_INDICES, {32'h0000_0101, 16'hFFFD});
    write_reg(REG_FILL_COLOR, 48'h1234_5678);
    queue_req(OP_START, 32'hFFFF_FFFF);
    queue_req(OP_ELEMENT, 32'h0000_0000);
    queue_req(OP_ELEMENT, 32'hFFFF_FFFF);
    queue_req(OP_ELEMENT, 32'h7856_3412);
    queue_req(OP_ELEMENT, 32'hA5A5_5A5A);
    queue_req(OP_ELEMENT, 32'h0BAD_F00D);
    wait_drained();

    // constant fill with transparency on: every element is skipped
    write_reg(REG_CHANNEL_CONTROL,
              48'({1'b0, 1'b0, SIZE_BYTE, 1'b1, 1'b1, MODE_CONST, MODE_SINGLE}));
    write_reg(REG_ELEMENTS_PER_FRAME, 48'hFF_FFFF);
    write_reg(REG_FRAMES_PER_BLOCK, 48'hFFFF);
    write_reg(REG_SOURCE_START, 48'hFFFF_FFFF);
    write_reg(REG_DEST_START, 48'h0);
    write_reg(REG_FILL_COLOR, 48'hA5);
    queue_req(OP_START, 32'h0);
    queue_req(OP_ELEMENT, 32'h0000_00A5);
    queue_req(OP_ELEMENT, 32'h1234_5600);
    wait_drained();

    // transparent skip on halfwords, constant source
    write_reg(REG_CHANNEL_CONTROL,
              48'({1'b0, 1'b0, SIZE_HALF, 1'b1, 1'b0, MODE_POST_INC, MODE_CONST}));
    write_reg(REG_SOURCE_START, 48'h40);
    write_reg(REG_DEST_START, 48'h80);
    write_reg(REG_FILL_COLOR, 48'hBEEF);
    queue_req(OP_START, 32'h0);
    queue_req(OP_ELEMENT, 32'h1234_BEEF);
    queue_req(OP_ELEMENT, 32'h0000_BEEE);
    wait_drained();

    // misaligned source halfword, then an element after the fault
    write_reg(REG_CHANNEL_CONTROL,
              48'({1'b0, 1'b0, SIZE_HALF, 1'b0, 1'b0, MODE_POST_INC, MODE_POST_INC}));
    write_reg(REG_SOURCE_START, 48'h101);
    queue_req(OP_START, 32'h0);
    queue_req(OP_ELEMENT, 32'h5555_AAAA);
    queue_req(OP_ELEMENT, 32'hAAAA_5555);
    wait_drained();

    // misaligned destination word
    write_reg(REG_CHANNEL_CONTROL,
              48'({1'b0, 1'b0, SIZE_WORD, 1'b0, 1'b0, MODE_POST_INC, MODE_POST_INC}));
    write_reg(REG_SOURCE_START, 48'h100);
    write_reg(REG_DEST_START, 48'h102);
    queue_req(OP_START, 32'h0);
    queue_req(OP_ELEMENT, 32'hC0DE_CAFE);
    wait_drained();

    // eight-byte element size
    write_reg(REG_CHANNEL_CONTROL,
              48'({1'b0, 1'b0, SIZE_FAULT, 1'b0, 1'b0, MODE_POST_INC, MODE_POST_INC}));
    write_reg(REG_DEST_START, 48'h100);
    queue_req(OP_START, 32'h0);
    queue_req(OP_ELEMENT, 32'h1357_9BDF);
    wait_drained();

    while (queued_total < TARGET_REQS) begin
      random_phase();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_writes.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
